/* rtl/core/sla_pkg.sv */
// Shared types and constants for the serial line assembler.
// Used by the top level and its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sla_pkg;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_DELIMITER = 2'd0,
    REG_IGNORE    = 2'd1,
    REG_CASE_MODE = 2'd2,
    REG_LINE_MODE = 2'd3
  } reg_idx_t;

  localparam logic [1:0] CASE_LOWER   = 2'd1;
  localparam logic [1:0] CASE_UPPER   = 2'd2;
  localparam logic       MODE_NEWLINE = 1'b1;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CASE_GAP = 8'h20;

endpackage
`default_nettype wire

/* rtl/core/sla_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/serial_line_assembler_top.sv */
// Serial line assembler top level: control state, line store and result path.
// Depends on sla_pkg and sla_ram.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input channel (in_valid/in_ready): one request per cycle when ready,
//   carrying a command (data byte, flush, clear, read stored char), the byte
//   and a read index. Data bytes are filtered, case folded and stored; a
//   delimiter or LF ends the line, BUFFER_BYTES-1 bytes end it with line_full.
//   Output channel (out_valid/out_ready): at most one result per request, in
//   request order: line complete, flushed line, or read data.
//   Config channel (cfg_valid/cfg_ready): always ready; writes delimiter,
//   ignore byte, case mode and line mode. Write only while the block is idle.
// Throughput and ordering
//   One request per cycle sustained while out_ready stays high. The edge that
//   accepts a request starts the synchronous read of the line store and loads
//   the read stage; the result then moves to the output register. Control
//   state (write index, quote flag, CR flag) updates in the accept cycle, so
//   each request sees the previous one's effect at once; a read follows a
//   write to the same entry without hazard because the write lands at the
//   earlier edge.
// Reset and stall
//   Reset clears the control state, config registers and valid flags; the
//   line store and result fields are not. When out_ready is low the output
//   holds, one more result may wait in the read stage, and then in_ready drops.
module serial_line_assembler_top #(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [5:0] in_read_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [1:0] out_result_kind,
  output logic      [5:0] out_line_length,
  output logic            out_line_full,
  output logic      [7:0] out_read_char,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int LW = (AW > 6) ? AW : 6;
  localparam logic [AW-1:0] LAST = AW'(BUFFER_BYTES - 1);

  // configuration registers
  logic [7:0] delimiter_r;
  logic [7:0] ignore_r;
  logic [1:0] case_mode_r;
  logic       line_mode_r;

  // control state
  logic [AW-1:0] wi_r, wi_nxt;
  logic          inq_r, inq_nxt;
  logic          cr_r, cr_nxt;

  // read stage (waits for the line store read data)
  logic              p_valid_r;
  sla_pkg::kind_t    p_kind_r;
  logic [5:0]        p_len_r;
  logic              p_full_r;
  logic              p_zero_r;

  // output register
  logic              out_valid_r;
  sla_pkg::kind_t    out_kind_r;
  logic [5:0]        out_len_r;
  logic              out_full_r;
  logic [7:0]        out_char_r;

  logic           accept, p_move;
  logic           res_valid;
  sla_pkg::kind_t res_kind;
  logic [AW-1:0]  res_len;
  logic           res_full;
  logic [LW-1:0]  res_len_ext;
  logic           mem_we, mem_re;
  logic [7:0]     fold_byte;
  logic [AW-1:0]  wi_inc;
  logic [LW-1:0]  ridx_ext;
  logic           ridx_oob;
  logic [7:0]     mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r <= sla_pkg::CH_LF;
      ignore_r    <= 8'h00;
      case_mode_r <= 2'd0;
      line_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      case (sla_pkg::reg_idx_t'(cfg_index))
        sla_pkg::REG_DELIMITER: delimiter_r <= cfg_data;
        sla_pkg::REG_IGNORE:    ignore_r    <= cfg_data;
        sla_pkg::REG_CASE_MODE: case_mode_r <= cfg_data[1:0];
        sla_pkg::REG_LINE_MODE: line_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // advance the read stage when the output register is free or being taken
  assign p_move   = p_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !p_valid_r || p_move;
  assign accept   = in_valid && in_ready;

  // fold ASCII letters only; case modes 0 and 3 leave bytes as they are
  always_comb begin
    fold_byte = in_data_byte;
    if (case_mode_r == sla_pkg::CASE_LOWER && in_data_byte >= 8'h41 && in_data_byte <= 8'h5A) begin
      fold_byte = in_data_byte + sla_pkg::CASE_GAP;
    end else if (case_mode_r == sla_pkg::CASE_UPPER && in_data_byte >= 8'h61 &&
                 in_data_byte <= 8'h7A) begin
      fold_byte = in_data_byte - sla_pkg::CASE_GAP;
    end
  end

  assign wi_inc   = wi_r + AW'(1);
  assign ridx_ext = LW'(in_read_index);
  assign ridx_oob = 32'(in_read_index) >= 32'(BUFFER_BYTES);

  always_comb begin
    wi_nxt    = wi_r;
    inq_nxt   = inq_r;
    cr_nxt    = cr_r;
    res_valid = 1'b0;
    res_kind  = sla_pkg::KIND_LINE;
    res_len   = '0;
    res_full  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    case (sla_pkg::cmd_t'(in_cmd))
      sla_pkg::CMD_DATA: begin
        if (line_mode_r != sla_pkg::MODE_NEWLINE && in_data_byte == sla_pkg::CH_QUOTE) begin
          inq_nxt = !inq_r;
        end else if (line_mode_r != sla_pkg::MODE_NEWLINE && !inq_r &&
                     in_data_byte == ignore_r) begin
          // drop the ignore byte
        end else if (line_mode_r != sla_pkg::MODE_NEWLINE && wi_r == '0 &&
                     in_data_byte == sla_pkg::CH_SPACE) begin
          // drop a leading space
        end else if (line_mode_r != sla_pkg::MODE_NEWLINE && in_data_byte == delimiter_r) begin
          inq_nxt   = 1'b0;
          wi_nxt    = '0;
          cr_nxt    = 1'b0;
          res_valid = (wi_r != '0);
          res_len   = wi_r;
        end else if (line_mode_r == sla_pkg::MODE_NEWLINE && in_data_byte == sla_pkg::CH_LF) begin
          // strip one trailing CR
          res_len   = (wi_r != '0 && cr_r) ? wi_r - AW'(1) : wi_r;
          res_valid = (res_len != '0);
          wi_nxt    = '0;
          cr_nxt    = 1'b0;
        end else begin
          mem_we = 1'b1;
          if (wi_inc == LAST) begin
            wi_nxt    = '0;
            cr_nxt    = 1'b0;
            if (line_mode_r != sla_pkg::MODE_NEWLINE) begin
              inq_nxt = 1'b0;
            end
            res_valid = 1'b1;
            res_len   = LAST;
            res_full  = 1'b1;
          end else begin
            wi_nxt = wi_inc;
            cr_nxt = (fold_byte == sla_pkg::CH_CR);
          end
        end
      end
      sla_pkg::CMD_FLUSH: begin
        wi_nxt    = '0;
        inq_nxt   = 1'b0;
        cr_nxt    = 1'b0;
        res_valid = 1'b1;
        res_kind  = sla_pkg::KIND_FLUSH;
        res_len   = wi_r;
      end
      sla_pkg::CMD_CLEAR: begin
        wi_nxt  = '0;
        inq_nxt = 1'b0;
        cr_nxt  = 1'b0;
      end
      sla_pkg::CMD_READ: begin
        res_valid = 1'b1;
        res_kind  = sla_pkg::KIND_READ;
        mem_re    = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_len_ext = LW'(res_len);

  sla_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (accept && mem_we),
    .waddr(wi_r),
    .wdata(fold_byte),
    .re   (accept && mem_re),
    .raddr(ridx_ext[AW-1:0]),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r  <= '0;
      inq_r <= 1'b0;
      cr_r  <= 1'b0;
    end else if (accept) begin
      wi_r  <= wi_nxt;
      inq_r <= inq_nxt;
      cr_r  <= cr_nxt;
    end
  end

  // hold the result here while the line store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (accept) begin
      p_valid_r <= res_valid;
    end else if (p_move) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_kind_r <= res_kind;
      p_len_r  <= res_len_ext[5:0];
      p_full_r <= res_full;
      p_zero_r <= ridx_oob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_kind_r <= p_kind_r;
      out_len_r  <= p_len_r;
      out_full_r <= p_full_r;
      out_char_r <= (p_kind_r == sla_pkg::KIND_READ && !p_zero_r) ? mem_rdata : 8'h00;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_line_length = out_len_r;
  assign out_line_full   = out_full_r;
  assign out_read_char   = out_char_r;

endmodule
`default_nettype wire

/* rtl/core/sla_checker.sv */
// Port-level checker for the serial line assembler, bound to the top level.
// Depends on sla_pkg and serial_line_assembler_top.
`timescale 1ns / 1ps
`default_nettype none
module sla_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_result_kind,
  input wire logic [5:0] out_line_length,
  input wire logic       out_line_full,
  input wire logic [7:0] out_read_char
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
    $stable(out_line_length) && $stable(out_line_full) && $stable(out_read_char))
    else $error("stalled result changed");

  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == sla_pkg::KIND_READ |->
    out_line_length == 6'd0 && !out_line_full)
    else $error("read result carries line fields");

  a_flush_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == sla_pkg::KIND_FLUSH |->
    !out_line_full && out_read_char == 8'h00)
    else $error("flush result carries stray fields");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind serial_line_assembler_top sla_checker u_sla_checker (.*);
`default_nettype wire
